@@ rtl/reed_solomon_parity_encoder_macros.svh @@
// assertion macros shared by the reed-solomon parity encoder rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef REED_SOLOMON_PARITY_ENCODER_MACROS_SVH
`define REED_SOLOMON_PARITY_ENCODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RSPE_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("rspe assertion failed");

// next-cycle implication, checked out of reset
`define RSPE_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("rspe assertion failed");

`endif

@@ rtl/rspe_pkg.sv @@
// shared types, constants and gf(256) arithmetic for the reed-solomon parity encoder
// no dependencies
`timescale 1ns / 1ps

package rspe_pkg;

  // field and sizing constants
  localparam int BYTE_W          = 8;
  localparam int CFG_W           = 6;
  localparam int MAX_PARITY_DEF  = 32;
  localparam int RESET_PARITY    = 10;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 3;

  localparam logic [8:0] FIELD_POLY = 9'h11D;
  localparam logic [8:0] FIELD_TOP  = 9'h100;

  // register index, taken from paddr above the byte offset
  localparam logic [APB_ADDR_W-3:0] REG_PARITY_COUNT = '0;

  // per-cycle commands broadcast along the cell row
  typedef struct packed {
    logic              clear;   // drop message, zero generator
    logic              build;   // one generator build step
    logic              absorb;  // message word accepted
    logic              finish;  // accepted word was the last one
    logic              shift;   // output word taken
    logic [BYTE_W-1:0] fb;      // lfsr feedback byte
    logic [BYTE_W-1:0] root;    // current generator root
  } rspe_ctrl_t;

  // multiply by alpha
  function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] x);
    logic [BYTE_W:0] wide;
    wide = {x, 1'b0};
    if ((wide & FIELD_TOP) != '0) begin
      wide = wide ^ FIELD_POLY;
    end
    return wide[BYTE_W-1:0];
  endfunction

  // full gf(256) multiply, shift-and-add over eight bits
  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] acc;
    x   = a;
    acc = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = gf_xtime(x);
    end
    return acc;
  endfunction

endpackage

@@ rtl/rspe_in_if.sv @@
// message word channel: valid/ready handshake with data byte and last flag
// depends on rspe_pkg
`timescale 1ns / 1ps

interface rspe_in_if;
  logic                            valid;
  logic                            ready;
  logic [rspe_pkg::BYTE_W-1:0]     data_byte;
  logic                            last_data;

  modport source (output valid, output data_byte, output last_data, input ready);
  modport sink   (input valid, input data_byte, input last_data, output ready);
endinterface

@@ rtl/rspe_out_if.sv @@
// parity word channel: valid/ready handshake with parity byte and last flag
// depends on rspe_pkg
`timescale 1ns / 1ps

interface rspe_out_if;
  logic                            valid;
  logic                            ready;
  logic [rspe_pkg::BYTE_W-1:0]     parity_byte;
  logic                            last_parity;

  modport source (output valid, output parity_byte, output last_parity, input ready);
  modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface

@@ rtl/rspe_cell.sv @@
// one cell of the encoder row: lfsr stage, output shift stage, generator coefficient
// depends on rspe_pkg
`timescale 1ns / 1ps

module rspe_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  rspe_pkg::rspe_ctrl_t         ctrl,
  input  logic [rspe_pkg::BYTE_W-1:0]  parity_in,  // lfsr byte of the next cell
  input  logic [rspe_pkg::BYTE_W-1:0]  hold_in,    // output byte of the next cell
  input  logic [rspe_pkg::BYTE_W-1:0]  coef_in,    // coefficient of the previous cell
  output logic [rspe_pkg::BYTE_W-1:0]  parity,
  output logic [rspe_pkg::BYTE_W-1:0]  hold,
  output logic [rspe_pkg::BYTE_W-1:0]  coef
);
  import rspe_pkg::*;

  logic [BYTE_W-1:0] mixed;

  // lfsr update: neighbor byte plus feedback times this cell's coefficient
  assign mixed = parity_in ^ gf_mul(ctrl.fb, coef);

  // lfsr stage and generator coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= '0;
      coef   <= '0;
    end else if (ctrl.clear) begin
      parity <= '0;
      coef   <= '0;
    end else begin
      if (ctrl.build) begin
        coef <= coef ^ gf_mul(ctrl.root, coef_in);
      end
      if (ctrl.absorb) begin
        parity <= ctrl.finish ? '0 : mixed;
      end
    end
  end

  // output stage: load the remainder at message end, then shift toward cell zero
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      hold <= mixed;
    end else if (ctrl.shift) begin
      hold <= hold_in;
    end
  end

endmodule

@@ rtl/reed_solomon_parity_encoder.sv @@
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D, built as a
// row of MAX_PARITY cells (rspe_cell, using rspe_pkg and the rspe_in_if / rspe_out_if
// channels). The generator has roots alpha^0 .. alpha^(n-1), n = parity_count (register at
// byte address 0, reset 10, 0 reads as 1, values above MAX_PARITY clamp; only the low six
// bits of a write are used). Message words enter on msg at one per clock; after the word
// flagged last, n parity words leave on par, highest order first, at one per clock while
// par is ready, from a separate output row, so the next message streams in while they
// drain. A last word is held off until the output row is free. A parity_count write clears
// the message in progress and rebuilds the generator, one root per cycle across all cells,
// and msg is not ready meanwhile; after reset the same build runs with the reset count.
`timescale 1ns / 1ps
`include "reed_solomon_parity_encoder_macros.svh"

module reed_solomon_parity_encoder #(
  parameter int MAX_PARITY = rspe_pkg::MAX_PARITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  rspe_in_if.sink                           msg,
  rspe_out_if.source                        par,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rspe_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rspe_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rspe_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import rspe_pkg::*;

  localparam int CW      = $clog2(MAX_PARITY + 1);
  localparam int RESET_N = (RESET_PARITY > MAX_PARITY) ? MAX_PARITY : RESET_PARITY;

  logic [CW-1:0]     parity_count;
  logic [CW-1:0]     build_cnt;
  logic [CW-1:0]     emit_cnt;
  logic [BYTE_W-1:0] root;
  logic [CW-1:0]     n_new;
  logic              cfg_we;
  logic              reg_hit;
  logic              in_fire;
  logic              out_fire;
  rspe_ctrl_t        ctrl;

  logic [BYTE_W-1:0] parity_q [MAX_PARITY];
  logic [BYTE_W-1:0] hold_q   [MAX_PARITY];
  logic [BYTE_W-1:0] coef_q   [MAX_PARITY];

  // configuration port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_PARITY_COUNT);
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? APB_DATA_W'(parity_count) : '0;

  // clamp written parity count into 1 .. MAX_PARITY
  always_comb begin
    if (pwdata[CFG_W-1:0] == '0) begin
      n_new = CW'(1);
    end else if (int'(pwdata[CFG_W-1:0]) > MAX_PARITY) begin
      n_new = CW'(MAX_PARITY);
    end else begin
      n_new = CW'(pwdata[CFG_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_count <= CW'(RESET_N);
    end else if (cfg_we) begin
      parity_count <= n_new;
    end
  end

  // generator build: one root per cycle, alpha^0 first
  always_ff @(posedge clk) begin
    if (rst) begin
      build_cnt <= CW'(RESET_N);
      root      <= BYTE_W'(1);
    end else if (cfg_we) begin
      build_cnt <= n_new;
      root      <= BYTE_W'(1);
    end else if (build_cnt != '0) begin
      build_cnt <= build_cnt - CW'(1);
      root      <= gf_xtime(root);
    end
  end

  // input handshake: a last word waits until the output row is free
  assign msg.ready = (build_cnt == '0) &&
                     (!msg.last_data || emit_cnt == '0 ||
                      (emit_cnt == CW'(1) && par.ready));
  assign in_fire   = msg.valid && msg.ready;
  assign out_fire  = par.valid && par.ready;

  // parity word counter
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_cnt <= '0;
    end else if (cfg_we) begin
      emit_cnt <= '0;
    end else if (in_fire && msg.last_data) begin
      emit_cnt <= parity_count;
    end else if (out_fire) begin
      emit_cnt <= emit_cnt - CW'(1);
    end
  end

  assign par.valid       = (emit_cnt != '0);
  assign par.last_parity = (emit_cnt == CW'(1));
  assign par.parity_byte = hold_q[0];

  // commands to the row
  always_comb begin
    ctrl.clear  = cfg_we;
    ctrl.build  = (build_cnt != '0);
    ctrl.absorb = in_fire;
    ctrl.finish = in_fire && msg.last_data;
    ctrl.shift  = out_fire;
    ctrl.fb     = msg.data_byte ^ parity_q[0];
    ctrl.root   = root;
  end

  // cell row: lfsr and output bytes flow toward cell zero, coefficients away from it
  for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
    logic [BYTE_W-1:0] p_in;
    logic [BYTE_W-1:0] h_in;
    logic [BYTE_W-1:0] c_in;

    if (j == MAX_PARITY - 1) begin : g_tail
      assign p_in = '0;
      assign h_in = '0;
    end else begin : g_mid
      assign p_in = parity_q[j+1];
      assign h_in = hold_q[j+1];
    end

    if (j == 0) begin : g_head
      assign c_in = BYTE_W'(1);
    end else begin : g_body
      assign c_in = coef_q[j-1];
    end

    rspe_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .parity_in (p_in),
      .hold_in   (h_in),
      .coef_in   (c_in),
      .parity    (parity_q[j]),
      .hold      (hold_q[j]),
      .coef      (coef_q[j])
    );
  end

  // checks
  `RSPE_ASSERT_IMP(a_build_blocks_input, clk, rst, build_cnt != '0, !msg.ready)
  `RSPE_ASSERT_IMP(a_emit_bound, clk, rst, 1'b1, emit_cnt <= parity_count)
  `RSPE_ASSERT_NXT(a_last_loads_count, clk, rst, in_fire && msg.last_data && !cfg_we, emit_cnt == parity_count)
  `RSPE_ASSERT_NXT(a_cfg_restarts, clk, rst, cfg_we, build_cnt == parity_count && emit_cnt == '0 && parity_q[0] == '0)
  `RSPE_ASSERT_NXT(a_drain_ends, clk, rst, out_fire && par.last_parity && !(in_fire && msg.last_data), !par.valid)

endmodule
